/* rtl/dcmf_pkg.sv */
// Shared types and codes of the dark channel minimum filter.
// Depends on nothing; used by the controller, the datapath and the top level.
package dcmf_pkg;

    // Item codes on the command field.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } dcmf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_scan;
        logic scan_step;
        logic finish;
    } dcmf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ready;
        logic scan_last;
        logic out_free;
    } dcmf_status_t;

endpackage

/* rtl/dark_channel_min_filter_top.sv */
// Top level of the dark channel minimum filter.
// Depends on dcmf_pkg, dcmf_ctrl and dcmf_dp.
//
// This block takes BGR pixels in raster order, keeps the minimum of the three
// channels of each pixel in a line store of 2*MAX_RADIUS+1 rows, and gives the
// dark channel: the minimum over a square window of side 2R+1 clipped at the
// image edges, in raster order, once the window has fully arrived. Each item
// takes one transfer on the input; a flush item gives a pending result without
// adding a pixel, and a pixel that arrives before the previous frame has
// drained is dropped. The input stalls until an item is through. An item that
// gives a result has its clipped window (up to (2R+1)^2 pixels) read from the
// single read port of the line store one entry per cycle; the result then
// waits in the output register until the receiver takes it. Each result
// carries the running maximum of the channel minima of the frame (the air
// light) and the last result of a frame is marked. The line store needs no
// clearing after reset.
module dark_channel_min_filter_top
    import dcmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  dark_value,
    output logic [7:0]  air_light,
    output logic        last_of_frame
);

    dcmf_cmd_t    cmd;
    dcmf_status_t status;
    dcmf_state_t  state;

    // The controller sequences check, window scan and result transfer.
    dcmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // The datapath holds the counters, the line store and the output register.
    dcmf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dark_value    (dark_value),
        .air_light     (air_light),
        .last_of_frame (last_of_frame)
    );

`ifndef SYNTH
    // An accepted item is always checked for a ready result next.
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state == S_CHECK))
        else $error("accepted item did not enter the check state");

    // A finished result always lands in the output register.
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result was not presented");

    // The scan only ends through the drain cycle.
    a_scan_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_SCAN) |=> (state == S_SCAN || state == S_DRAIN))
        else $error("window scan left its sequence");
`endif

endmodule

/* rtl/dcmf_ctrl.sv */
// Controller state machine of the dark channel minimum filter.
// Depends on dcmf_pkg for the state enum and the command and status structs.
module dcmf_ctrl
    import dcmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  dcmf_status_t status,
    output dcmf_cmd_t    cmd,
    output dcmf_state_t  state
);

    dcmf_state_t state_reg;
    dcmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.ready ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.accept    = 1'b0;
        cmd.load_scan = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_CHECK:
            begin
                cmd.load_scan = status.ready;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.finish = 1'b0;
            end
            S_RESULT:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign state = state_reg;

endmodule

/* rtl/dcmf_dp.sv */
// Datapath of the dark channel minimum filter: configuration, counters,
// line store, window scan and output register. Depends on dcmf_pkg.
module dcmf_dp
    import dcmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data,
    input  logic         command,
    input  logic [7:0]   blue,
    input  logic [7:0]   green,
    input  logic [7:0]   red,
    input  dcmf_cmd_t    cmd,
    output dcmf_status_t status,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   dark_value,
    output logic [7:0]   air_light,
    output logic         last_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CH    = $clog2(MAX_HEIGHT);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int DEPTH = SLOTS * (2 ** CW);

    logic [11:0] width_reg, height_reg;
    logic [2:0]  radius_reg;

    logic [CH-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [SW-1:0] in_slot_reg, out_slot_reg;
    logic          frame_recv_reg;
    logic [7:0]    bright_reg;

    logic [CH-1:0] y_reg, y_end_reg;
    logic [CW-1:0] x_reg, x0_reg, x1_reg;
    logic [SW-1:0] y_slot_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic [7:0]    dark_reg;

    logic       out_valid_reg;
    logic [7:0] dark_out_reg, air_out_reg;
    logic       last_out_reg;

    logic [7:0] mem [DEPTH];

    logic [CW-1:0] wm1;
    logic [CH-1:0] hm1;
    logic [RW-1:0] rad;
    logic [7:0]    chan_min;
    logic          pix_write;
    logic [CH:0]   row_sum, row_lo;
    logic [CW:0]   col_sum, col_lo;
    logic [CH-1:0] need_row, r0;
    logic [CW-1:0] need_col, c0;
    logic [SW-1:0] slot0;
    logic          last_pos;
    int            d_row;

    always_comb
    begin
        if (width_reg == 12'd0)
            wm1 = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(width_reg - 12'd1);
        if (height_reg == 12'd0)
            hm1 = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            hm1 = CH'(MAX_HEIGHT - 1);
        else
            hm1 = CH'(height_reg - 12'd1);
        if (32'(radius_reg) > MAX_RADIUS)
            rad = RW'(MAX_RADIUS);
        else
            rad = RW'(radius_reg);
    end

    always_comb
    begin
        chan_min = (blue < green) ? blue : green;
        chan_min = (red < chan_min) ? red : chan_min;
    end

    assign pix_write = cmd.accept && (command == CMD_PIXEL) && !frame_recv_reg;

    // Window bounds of the next result position.
    always_comb
    begin
        row_sum  = {1'b0, out_row_reg} + (CH+1)'(rad);
        need_row = (row_sum < {1'b0, hm1}) ? row_sum[CH-1:0] : hm1;
        col_sum  = {1'b0, out_col_reg} + (CW+1)'(rad);
        need_col = (col_sum < {1'b0, wm1}) ? col_sum[CW-1:0] : wm1;
        row_lo   = ({1'b0, out_row_reg} > (CH+1)'(rad)) ?
                   ({1'b0, out_row_reg} - (CH+1)'(rad)) : '0;
        r0       = (row_lo[CH-1:0] > need_row) ? need_row : row_lo[CH-1:0];
        col_lo   = ({1'b0, out_col_reg} > (CW+1)'(rad)) ?
                   ({1'b0, out_col_reg} - (CW+1)'(rad)) : '0;
        c0       = (col_lo[CW-1:0] > need_col) ? need_col : col_lo[CW-1:0];
        d_row    = int'(out_row_reg) - int'(r0);
        if (d_row <= int'(out_slot_reg))
            slot0 = SW'(int'(out_slot_reg) - d_row);
        else
            slot0 = SW'(int'(out_slot_reg) + SLOTS - d_row);
        last_pos = (out_row_reg >= hm1) && (out_col_reg >= wm1);
    end

    assign status.ready = frame_recv_reg || (in_row_reg > need_row) ||
                          ((in_row_reg == need_row) && (in_col_reg > need_col));
    assign status.scan_last = (x_reg == x1_reg) && (y_reg == y_end_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            radius_reg <= 3'd7;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // Frame counters; the slot registers follow the rows modulo the slot count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_slot_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_slot_reg   <= '0;
            frame_recv_reg <= 1'b0;
            bright_reg     <= 8'd0;
        end
        else if (pix_write)
        begin
            if (in_row_reg == '0 && in_col_reg == '0)
                bright_reg <= chan_min;
            else if (chan_min > bright_reg)
                bright_reg <= chan_min;
            if (in_col_reg >= wm1)
            begin
                in_col_reg <= '0;
                if (in_row_reg >= hm1)
                begin
                    in_row_reg     <= '0;
                    in_slot_reg    <= '0;
                    frame_recv_reg <= 1'b1;
                end
                else
                begin
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_slot_reg <= (in_slot_reg == SW'(SLOTS - 1)) ? '0 :
                                   in_slot_reg + 1'b1;
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            if (last_pos)
            begin
                out_row_reg    <= '0;
                out_col_reg    <= '0;
                out_slot_reg   <= '0;
                in_row_reg     <= '0;
                in_col_reg     <= '0;
                in_slot_reg    <= '0;
                frame_recv_reg <= 1'b0;
            end
            else if (out_col_reg >= wm1)
            begin
                out_col_reg  <= '0;
                out_row_reg  <= out_row_reg + 1'b1;
                out_slot_reg <= (out_slot_reg == SW'(SLOTS - 1)) ? '0 :
                                out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_reg <= out_col_reg + 1'b1;
            end
        end
    end

    // Line store: one write port for pixels, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (pix_write)
            mem[{in_slot_reg, in_col_reg}] <= chan_min;
        if (cmd.scan_step)
            rd_data_reg <= mem[{y_slot_reg, x_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_scan)
        begin
            y_reg      <= r0;
            y_end_reg  <= need_row;
            x_reg      <= c0;
            x0_reg     <= c0;
            x1_reg     <= need_col;
            y_slot_reg <= slot0;
            dark_reg   <= 8'd255;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                if (x_reg == x1_reg)
                begin
                    x_reg      <= x0_reg;
                    y_reg      <= y_reg + 1'b1;
                    y_slot_reg <= (y_slot_reg == SW'(SLOTS - 1)) ? '0 :
                                  y_slot_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            if (rd_valid_reg && rd_data_reg < dark_reg)
                dark_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            dark_out_reg <= dark_reg;
            air_out_reg  <= bright_reg;
            last_out_reg <= last_pos;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dark_value    = dark_out_reg;
    assign air_light     = air_out_reg;
    assign last_of_frame = last_out_reg;

endmodule
